@@ rtl/core/scvu_pkg.sv @@
// ----------------------------------------------------------------------------
// scvu_pkg
// Shared types, constants and a saturating add helper for the spring chain
// velocity update datapath (Q16.16 words).
// ----------------------------------------------------------------------------
package scvu_pkg;

  localparam int W          = 32;
  localparam int LEN_W      = 31;
  localparam int DRAG_W     = 17;
  localparam int CFG_AW     = 5;
  localparam int SQRT_LAT   = 16;
  localparam int MULDIV_LAT = 10;
  // squares, sum, root, stretch, two scale units
  localparam int SPRING_LAT = 2 + SQRT_LAT + 1 + 2 * MULDIV_LAT;

  localparam logic [DRAG_W-1:0] DRAG_ONE = 17'd65536;
  localparam logic signed [W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [W-1:0] S_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_LEN    = 3'd0,
    REG_MASS   = 3'd1,
    REG_GRAV   = 3'd2,
    REG_SPRING = 3'd3,
    REG_DRAG   = 3'd4
  } reg_idx_t;

  typedef logic signed [W-1:0] word_t;
  typedef word_t [2:0] vec_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  mass;
    word_t             grav;
    logic [LEN_W-1:0]  spring;
    logic [DRAG_W-1:0] drag;
  } cfg_t;

  typedef struct packed {
    logic  ovf;
    word_t val;
  } sat_t;

  typedef struct packed {
    vec_t acc;
    logic ovf;
  } spring_res_t;

  typedef struct packed {
    vec_t vel;
    logic has_prev;
    logic has_next;
  } side_t;

  // signed add clipped to the word range
  function automatic sat_t sat_add(word_t a, word_t b);
    logic [W:0] s;
    sat_t       r;
    s     = {a[W-1], a} + {b[W-1], b};
    r.ovf = s[W] ^ s[W-1];
    r.val = r.ovf ? (s[W] ? S_MIN : S_MAX) : word_t'(s[W-1:0]);
    return r;
  endfunction

endpackage

@@ rtl/core/scvu_in_if.sv @@
// ----------------------------------------------------------------------------
// scvu_in_if
// Request channel into the velocity update: velocity and two neighbor
// displacements with presence marks.
// ----------------------------------------------------------------------------
interface scvu_in_if;
  logic            valid;
  logic            ready;
  scvu_pkg::word_t vel_x;
  scvu_pkg::word_t vel_y;
  scvu_pkg::word_t vel_z;
  scvu_pkg::word_t prev_dx;
  scvu_pkg::word_t prev_dy;
  scvu_pkg::word_t prev_dz;
  scvu_pkg::word_t next_dx;
  scvu_pkg::word_t next_dy;
  scvu_pkg::word_t next_dz;
  logic            has_prev;
  logic            has_next;

  modport source (output valid, vel_x, vel_y, vel_z, prev_dx, prev_dy, prev_dz,
                  next_dx, next_dy, next_dz, has_prev, has_next, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, prev_dx, prev_dy, prev_dz,
                  next_dx, next_dy, next_dz, has_prev, has_next, output ready);
endinterface

@@ rtl/core/scvu_out_if.sv @@
// ----------------------------------------------------------------------------
// scvu_out_if
// Result channel of the velocity update: new velocity and clip flag.
// ----------------------------------------------------------------------------
interface scvu_out_if;
  logic            valid;
  logic            ready;
  scvu_pkg::word_t new_vel_x;
  scvu_pkg::word_t new_vel_y;
  scvu_pkg::word_t new_vel_z;
  logic            saturated;

  modport source (output valid, new_vel_x, new_vel_y, new_vel_z, saturated,
                  input ready);
  modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z, saturated,
                  output ready);
endinterface

@@ rtl/core/scvu_cfg.sv @@
// ----------------------------------------------------------------------------
// scvu_cfg
// APB register file: rest length, mass, gravity, stiffness and drag.
// ----------------------------------------------------------------------------
module scvu_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scvu_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output scvu_pkg::cfg_t              cfg
);

  scvu_pkg::cfg_t     cfg_r;
  scvu_pkg::cfg_t     cfg_nxt;
  scvu_pkg::reg_idx_t idx;

  assign idx    = scvu_pkg::reg_idx_t'(paddr[scvu_pkg::CFG_AW-1:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // write decode; zero length/mass become 1 LSB, drag clips at 1.0
  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        scvu_pkg::REG_LEN:
          cfg_nxt.len = (pwdata[30:0] == '0) ? 31'd1 : pwdata[30:0];
        scvu_pkg::REG_MASS:
          cfg_nxt.mass = (pwdata[30:0] == '0) ? 31'd1 : pwdata[30:0];
        scvu_pkg::REG_GRAV:
          cfg_nxt.grav = scvu_pkg::word_t'(pwdata);
        scvu_pkg::REG_SPRING:
          cfg_nxt.spring = pwdata[30:0];
        scvu_pkg::REG_DRAG:
          cfg_nxt.drag = (pwdata[16:0] > scvu_pkg::DRAG_ONE) ? scvu_pkg::DRAG_ONE
                                                             : pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.len    <= 31'd65536;
      cfg_r.mass   <= 31'd65536;
      cfg_r.grav   <= 32'sd642711;
      cfg_r.spring <= 31'd65536;
      cfg_r.drag   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      scvu_pkg::REG_LEN:    prdata = {1'b0, cfg_r.len};
      scvu_pkg::REG_MASS:   prdata = {1'b0, cfg_r.mass};
      scvu_pkg::REG_GRAV:   prdata = cfg_r.grav;
      scvu_pkg::REG_SPRING: prdata = {1'b0, cfg_r.spring};
      scvu_pkg::REG_DRAG:   prdata = {15'd0, cfg_r.drag};
      default:              prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/scvu_delay.sv @@
// ----------------------------------------------------------------------------
// scvu_delay
// Enabled shift line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module scvu_delay #(
  parameter type T     = logic,
  parameter int  DEPTH = 1
) (
  input  logic clk,
  input  logic en,
  input  T     din,
  output T     dout
);

  T pipe_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign dout = pipe_r[DEPTH-1];

endmodule

@@ rtl/core/scvu_isqrt.sv @@
// ----------------------------------------------------------------------------
// scvu_isqrt
// Pipelined floor square root of a 64-bit value, two result bits a stage.
// ----------------------------------------------------------------------------
module scvu_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  localparam int PER  = 2;
  localparam int NSTG = scvu_pkg::SQRT_LAT;

  logic [63:0] x_r   [NSTG];
  logic [63:0] res_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [63:0] x_in, res_in, x_nxt, res_nxt;

    if (s == 0) begin : g_first
      assign x_in   = rad;
      assign res_in = '0;
    end else begin : g_rest
      assign x_in   = x_r[s-1];
      assign res_in = res_r[s-1];
    end

    // restoring root step per bit pair
    always_comb begin
      logic [63:0] pw;
      x_nxt   = x_in;
      res_nxt = res_in;
      for (int j = 0; j < PER; j++) begin
        pw = 64'd1 << (62 - 2 * (PER * s + j));
        if (x_nxt >= res_nxt + pw) begin
          x_nxt   = x_nxt - (res_nxt + pw);
          res_nxt = (res_nxt >> 1) + pw;
        end else begin
          res_nxt = res_nxt >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s]   <= x_nxt;
        res_r[s] <= res_nxt;
      end
    end
  end

  assign root = res_r[NSTG-1][31:0];

endmodule

@@ rtl/core/scvu_muldiv.sv @@
// ----------------------------------------------------------------------------
// scvu_muldiv
// trunc(val * num / den) clipped to the word range: one multiply stage,
// eight long-division stages of four bits, one sign and clip stage.
// ----------------------------------------------------------------------------
module scvu_muldiv (
  input  logic            clk,
  input  logic            en,
  input  scvu_pkg::word_t val,
  input  logic [31:0]     num,
  input  logic [30:0]     den,
  output scvu_pkg::word_t q,
  output logic            ovf
);

  localparam int QW   = 32;
  localparam int BPS  = 4;
  localparam int NDIV = QW / BPS;

  logic [31:0]     mag;
  logic            neg_r;
  logic [63:0]     prod_r;
  logic            dneg_r [NDIV];
  logic            big_r  [NDIV];
  logic [30:0]     rem_r  [NDIV];
  logic [31:0]     lo_r   [NDIV];
  logic [31:0]     quo_r  [NDIV];
  scvu_pkg::word_t q_r;
  logic            ovf_r;

  // magnitude product
  assign mag = val[31] ? 32'(-val) : 32'(val);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= val[31];
      prod_r <= 64'(mag) * 64'(num);
    end
  end

  for (genvar s = 0; s < NDIV; s++) begin : g_div
    logic        neg_in, big_in;
    logic [30:0] rem_in, rem_nxt;
    logic [31:0] lo_in, lo_nxt, quo_in, quo_nxt;

    if (s == 0) begin : g_first
      // quotient at or above 2^32 is clipped anyway
      assign neg_in = neg_r;
      assign big_in = prod_r[63:32] >= {1'b0, den};
      assign rem_in = prod_r[62:32];
      assign lo_in  = prod_r[31:0];
      assign quo_in = '0;
    end else begin : g_rest
      assign neg_in = dneg_r[s-1];
      assign big_in = big_r[s-1];
      assign rem_in = rem_r[s-1];
      assign lo_in  = lo_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin
      logic [31:0] t;
      rem_nxt = rem_in;
      lo_nxt  = lo_in;
      quo_nxt = quo_in;
      for (int j = 0; j < BPS; j++) begin
        t      = {rem_nxt, lo_nxt[31]};
        lo_nxt = lo_nxt << 1;
        if (t >= {1'b0, den}) begin
          t       = t - {1'b0, den};
          quo_nxt = {quo_nxt[30:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[30:0], 1'b0};
        end
        rem_nxt = t[30:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dneg_r[s] <= neg_in;
        big_r[s]  <= big_in;
        rem_r[s]  <= rem_nxt;
        lo_r[s]   <= lo_nxt;
        quo_r[s]  <= quo_nxt;
      end
    end
  end

  // sign restore and clip; negative side reaches one step further
  always_ff @(posedge clk) begin
    logic [31:0] qf;
    logic        nf, over;
    if (en) begin
      qf   = quo_r[NDIV-1];
      nf   = dneg_r[NDIV-1];
      over = big_r[NDIV-1] || (qf[31] && (!nf || (qf[30:0] != '0)));
      ovf_r <= over;
      if (over) begin
        q_r <= nf ? scvu_pkg::S_MIN : scvu_pkg::S_MAX;
      end else begin
        q_r <= nf ? scvu_pkg::word_t'(-qf) : scvu_pkg::word_t'(qf);
      end
    end
  end

  assign q   = q_r;
  assign ovf = ovf_r;

endmodule

@@ rtl/core/scvu_spring.sv @@
// ----------------------------------------------------------------------------
// scvu_spring
// Acceleration from one neighbor: distance by root of summed squares,
// then d * (dist - L) / L and * k / m per component when stretched.
// ----------------------------------------------------------------------------
module scvu_spring (
  input  logic                  clk,
  input  logic                  en,
  input  scvu_pkg::vec_t        d,
  input  logic                  has,
  input  logic [30:0]           len,
  input  logic [30:0]           mass,
  input  logic [30:0]           spring_k,
  output scvu_pkg::spring_res_t res
);

  typedef struct packed {
    scvu_pkg::vec_t d;
    logic           has;
  } dside_t;

  logic [31:0]    mag [3];
  logic [63:0]    sq_r [3];
  logic [63:0]    sum_r;
  logic [31:0]    root;
  dside_t         side_in, side_d;
  logic           act_r;
  logic [31:0]    stretch_r;
  scvu_pkg::vec_t d_r;
  scvu_pkg::vec_t t, a;
  logic [2:0]     ft, fa;
  logic           act_t;
  logic [3:0]     late;

  // component squares, then their sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i][31] ? 32'(-d[i]) : 32'(d[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 64'(mag[i]) * 64'(mag[i]);
      end
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  scvu_isqrt u_isqrt (.clk(clk), .en(en), .rad(sum_r), .root(root));

  assign side_in = '{d: d, has: has};

  scvu_delay #(.T(dside_t), .DEPTH(2 + scvu_pkg::SQRT_LAT)) u_side (
    .clk(clk), .en(en), .din(side_in), .dout(side_d)
  );

  // stretch beyond rest length
  always_ff @(posedge clk) begin
    if (en) begin
      act_r     <= side_d.has && (root > {1'b0, len});
      stretch_r <= root - {1'b0, len};
      d_r       <= side_d.d;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_comp
    scvu_muldiv u_stretch (
      .clk(clk), .en(en), .val(d_r[i]), .num(stretch_r), .den(len),
      .q(t[i]), .ovf(ft[i])
    );
    scvu_muldiv u_force (
      .clk(clk), .en(en), .val(t[i]), .num({1'b0, spring_k}), .den(mass),
      .q(a[i]), .ovf(fa[i])
    );
  end

  scvu_delay #(.T(logic), .DEPTH(scvu_pkg::MULDIV_LAT)) u_act (
    .clk(clk), .en(en), .din(act_r), .dout(act_t)
  );

  scvu_delay #(.T(logic [3:0]), .DEPTH(scvu_pkg::MULDIV_LAT)) u_late (
    .clk(clk), .en(en), .din({act_t, ft}), .dout(late)
  );

  // an idle or slack neighbor adds nothing and flags nothing
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res.acc[i] = late[3] ? a[i] : '0;
    end
    res.ovf = late[3] && ((late[2:0] != '0) || (fa != '0));
  end

endmodule

@@ rtl/core/spring_chain_velocity_update.sv @@
// ----------------------------------------------------------------------------
// spring_chain_velocity_update
// Mass-spring velocity step for one chain node with gravity and drag.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch carries a node request: velocity, displacements to the previous and
//  next neighbor and their presence marks. out_ch returns the new velocity
//  and a flag that is set when any intermediate value was clipped.
//  Both channels are valid/ready; a request moves when both are high.
//  The cfg_ APB port sets rest length, mass, gravity, stiffness and drag;
//  write it only while no request is in flight.
//  Each neighbor path runs squares (2), a 16-stage root, a stretch stage
//  and two 10-stage multiply-divide units; four stages then add gravity,
//  apply drag and clip. Throughput: one request per cycle unless a
//  finished result waits on a low out_ch.ready.
//  Reset clears every valid bit and loads the register defaults.
//  A stalled result holds the whole pipeline in place; in_ch.ready drops
//  only while a finished result waits and out_ch.ready is low.
// ----------------------------------------------------------------------------
module spring_chain_velocity_update (
  input  logic                        clk,
  input  logic                        rst_n,
  scvu_in_if.sink                     in_ch,
  scvu_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [scvu_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int SL = scvu_pkg::SPRING_LAT;

  scvu_pkg::cfg_t        cfg;
  logic                  en;
  scvu_pkg::vec_t        dp, dn;
  scvu_pkg::side_t       side_in, side_d;
  scvu_pkg::spring_res_t sp_p, sp_n;

  logic [SL-1:0]   vld_r;
  logic            vld1_r, vld2_r, vld3_r, vld4_r;
  scvu_pkg::vec_t  vel1_r, acc1_r, acc1_nxt;
  logic            pass1_r, flag1_r, flag1_nxt;
  scvu_pkg::vec_t  v2_r, v2_nxt;
  logic            pass2_r, flag2_r, flag2_nxt;
  scvu_pkg::vec_t  v3_r;
  logic [47:0]     prod3_r [3];
  logic [47:0]     prod3_nxt [3];
  logic            pass3_r, flag3_r;
  scvu_pkg::vec_t  out_r, out_nxt;
  logic            pass4_r, flag4_r;

  scvu_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  // whole pipeline moves unless a result is stuck at the output
  assign en          = !vld4_r || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    dp[0] = in_ch.prev_dx;
    dp[1] = in_ch.prev_dy;
    dp[2] = in_ch.prev_dz;
    dn[0] = in_ch.next_dx;
    dn[1] = in_ch.next_dy;
    dn[2] = in_ch.next_dz;
    side_in.vel[0]   = in_ch.vel_x;
    side_in.vel[1]   = in_ch.vel_y;
    side_in.vel[2]   = in_ch.vel_z;
    side_in.has_prev = in_ch.has_prev;
    side_in.has_next = in_ch.has_next;
  end

  scvu_spring u_prev (
    .clk(clk), .en(en), .d(dp), .has(in_ch.has_prev), .len(cfg.len),
    .mass(cfg.mass), .spring_k(cfg.spring), .res(sp_p)
  );

  scvu_spring u_next (
    .clk(clk), .en(en), .d(dn), .has(in_ch.has_next), .len(cfg.len),
    .mass(cfg.mass), .spring_k(cfg.spring), .res(sp_n)
  );

  scvu_delay #(.T(scvu_pkg::side_t), .DEPTH(SL)) u_side (
    .clk(clk), .en(en), .din(side_in), .dout(side_d)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld_r  <= {vld_r[SL-2:0], in_ch.valid};
      vld1_r <= vld_r[SL-1];
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  // stage 1: gravity plus both spring terms
  always_comb begin
    scvu_pkg::word_t base, gneg;
    scvu_pkg::sat_t  s1, s2;
    logic            gflag;
    gflag     = (cfg.grav == scvu_pkg::S_MIN);
    gneg      = gflag ? scvu_pkg::S_MAX : scvu_pkg::word_t'(-cfg.grav);
    flag1_nxt = gflag | sp_p.ovf | sp_n.ovf;
    for (int i = 0; i < 3; i++) begin
      base        = (i == 1) ? gneg : '0;
      s1          = scvu_pkg::sat_add(base, sp_p.acc[i]);
      s2          = scvu_pkg::sat_add(s1.val, sp_n.acc[i]);
      acc1_nxt[i] = s2.val;
      flag1_nxt   = flag1_nxt | s1.ovf | s2.ovf;
    end
  end

  // stage 2: velocity plus acceleration, bypass with no neighbor
  always_comb begin
    scvu_pkg::sat_t s;
    logic           f;
    f = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s         = scvu_pkg::sat_add(vel1_r[i], acc1_r[i]);
      v2_nxt[i] = pass1_r ? vel1_r[i] : s.val;
      f         = f | s.ovf;
    end
    flag2_nxt = !pass1_r && (flag1_r || f);
  end

  // stage 3: drag product on the magnitude
  always_comb begin
    logic [31:0] m;
    for (int i = 0; i < 3; i++) begin
      m            = v2_r[i][31] ? 32'(-v2_r[i]) : 32'(v2_r[i]);
      prod3_nxt[i] = 48'(m) * 48'(cfg.drag);
    end
  end

  // stage 4: subtract the truncated drag term
  always_comb begin
    logic [31:0] term;
    logic [32:0] diff;
    for (int i = 0; i < 3; i++) begin
      term = prod3_r[i][47:16];
      if (v3_r[i][31]) begin
        diff = {v3_r[i][31], v3_r[i]} + {1'b0, term};
      end else begin
        diff = {v3_r[i][31], v3_r[i]} - {1'b0, term};
      end
      out_nxt[i] = pass3_r ? v3_r[i] : scvu_pkg::word_t'(diff[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel1_r  <= side_d.vel;
      pass1_r <= !side_d.has_prev && !side_d.has_next;
      acc1_r  <= acc1_nxt;
      flag1_r <= flag1_nxt;
      v2_r    <= v2_nxt;
      pass2_r <= pass1_r;
      flag2_r <= flag2_nxt;
      v3_r    <= v2_r;
      prod3_r <= prod3_nxt;
      pass3_r <= pass2_r;
      flag3_r <= flag2_r;
      out_r   <= out_nxt;
      pass4_r <= pass3_r;
      flag4_r <= flag3_r;
    end
  end

  assign out_ch.valid     = vld4_r;
  assign out_ch.new_vel_x = out_r[0];
  assign out_ch.new_vel_y = out_r[1];
  assign out_ch.new_vel_z = out_r[2];
  assign out_ch.saturated = flag4_r;

  // a node without neighbors never reports clipping
  a_pass_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (vld4_r && pass4_r) |-> !flag4_r)
    else $error("pass-through result carries a clip flag");

  // a stall freezes every valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({vld_r, vld1_r, vld2_r, vld3_r, vld4_r}))
    else $error("pipeline moved during a stall");

  // divisors stay nonzero and drag stays within one
  a_cfg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg.len != '0) && (cfg.mass != '0) && (cfg.drag <= scvu_pkg::DRAG_ONE))
    else $error("configuration out of range");

  // a result taken with ready high makes room for a new request
  a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (vld4_r && out_ch.ready) |-> in_ch.ready)
    else $error("input blocked while output drains");

endmodule
